>>> hw/rtl/iem_pkg.sv
// Package for the ICMP echo reply matcher.
// Holds the verdict codes, register indexes, protocol constants and the
// structs for the configuration and the item passed from the input stage to the parser. No dependencies.
package iem_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned COUNT_W   = 7;
    localparam int unsigned OFFSET_W  = 6;
    localparam int unsigned FIELD16_W = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
    localparam logic [7:0]         ICMP_MIN  = 8'd8;
    localparam logic [7:0]         V6_REPLY  = 8'd129;
    localparam logic [7:0]         V4_REPLY  = 8'd0;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IPV6_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_SOCKET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_ID  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_SEQ = 2'd3;

    typedef enum logic [2:0] {
        VERDICT_MATCH    = 3'd0,
        VERDICT_SHORT    = 3'd1,
        VERDICT_TYPE     = 3'd2,
        VERDICT_SEQ      = 3'd3,
        VERDICT_ID       = 3'd4
    } t_verdict;

    typedef struct packed {
        logic                 ipv6_mode;
        logic                 raw_socket;
        logic [FIELD16_W-1:0] expected_id;
        logic [FIELD16_W-1:0] expected_seq;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              last_byte;
    } t_in_item;

endpackage

>>> hw/rtl/iem_in_stage.sv
// Input register stage of the ICMP echo reply matcher.
// Holds one received byte until the parser takes it. Uses iem_pkg.
module iem_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [iem_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                          i_last_byte,
    input  logic                          i_take,
    output iem_pkg::t_in_item             o_item
);

    logic                       r_valid;
    logic                       n_valid;
    logic [iem_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;
    logic                       accept;

    // the register frees up in the same cycle the parser takes its item
    assign o_in_stall = r_valid && !i_take;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
            r_last <= i_last_byte;
        end
    end

    assign o_item.valid     = r_valid;
    assign o_item.rx_byte   = r_byte;
    assign o_item.last_byte = r_last;

endmodule

>>> hw/rtl/iem_parser.sv
// Packet parser and verdict register of the ICMP echo reply matcher.
// Tracks the byte position, captures type, identifier and sequence, and
// registers one verdict per packet. Uses iem_pkg.
module iem_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  iem_pkg::t_cfg                 i_cfg,
    input  iem_pkg::t_in_item             i_item,
    output logic                          o_take,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_accepted,
    output logic [2:0]                    o_verdict
);

    logic [iem_pkg::COUNT_W-1:0]   r_byte_count;
    logic [iem_pkg::COUNT_W-1:0]   n_byte_count;
    logic [iem_pkg::OFFSET_W-1:0]  r_header_offset;
    logic [iem_pkg::OFFSET_W-1:0]  n_header_offset;
    logic [7:0]                    r_type_seen;
    logic [7:0]                    n_type_seen;
    logic [iem_pkg::FIELD16_W-1:0] r_id_seen;
    logic [iem_pkg::FIELD16_W-1:0] n_id_seen;
    logic [iem_pkg::FIELD16_W-1:0] r_seq_seen;
    logic [iem_pkg::FIELD16_W-1:0] n_seq_seen;

    logic                          r_out_valid;
    logic                          n_out_valid;
    iem_pkg::t_verdict             r_verdict;
    iem_pkg::t_verdict             n_verdict;

    logic                          out_free;
    logic [iem_pkg::COUNT_W-1:0]   pos;
    logic [iem_pkg::OFFSET_W-1:0]  off;
    logic [iem_pkg::COUNT_W-1:0]   off_w;
    logic [7:0]                    reply_type;
    logic                          too_short;
    logic [7:0]                    b;

    assign out_free = !r_out_valid || !i_out_stall;
    // a last byte needs room for its verdict; other bytes pass freely
    assign o_take   = i_item.valid && (!i_item.last_byte || out_free);

    assign b     = i_item.rx_byte;
    assign pos   = r_byte_count;
    assign off_w = {1'b0, off};

    always_comb begin
        // offset fixed at byte 0: from the header-length nibble for raw IPv4, else zero
        off = r_header_offset;
        if (pos == '0) begin
            if (i_cfg.raw_socket && !i_cfg.ipv6_mode) begin
                off = {b[3:0], 2'b00};
            end else begin
                off = '0;
            end
        end
    end

    always_comb begin
        n_type_seen = r_type_seen;
        n_id_seen   = r_id_seen;
        n_seq_seen  = r_seq_seen;
        priority if (pos == off_w) begin
            n_type_seen = b;
        end else if (pos == off_w + 7'd4) begin
            n_id_seen[15:8] = b;
        end else if (pos == off_w + 7'd5) begin
            n_id_seen[7:0] = b;
        end else if (pos == off_w + 7'd6) begin
            n_seq_seen[15:8] = b;
        end else if (pos == off_w + 7'd7) begin
            n_seq_seen[7:0] = b;
        end else begin
            // no captured field at this position
        end
    end

    assign reply_type = i_cfg.ipv6_mode ? iem_pkg::V6_REPLY : iem_pkg::V4_REPLY;
    assign too_short  = ({1'b0, pos} + 8'd1) < ({2'b00, off} + iem_pkg::ICMP_MIN);

    always_comb begin
        priority if (too_short) begin
            n_verdict = iem_pkg::VERDICT_SHORT;
        end else if (n_type_seen != reply_type) begin
            n_verdict = iem_pkg::VERDICT_TYPE;
        end else if (n_seq_seen != i_cfg.expected_seq) begin
            n_verdict = iem_pkg::VERDICT_SEQ;
        end else if (i_cfg.raw_socket && n_id_seen != i_cfg.expected_id) begin
            n_verdict = iem_pkg::VERDICT_ID;
        end else begin
            n_verdict = iem_pkg::VERDICT_MATCH;
        end
    end

    assign n_byte_count    = (pos == iem_pkg::COUNT_MAX) ? pos : pos + 7'd1;
    assign n_header_offset = off;

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_free) begin
            n_out_valid = o_take && i_item.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_header_offset <= '0;
            r_type_seen     <= '0;
            r_id_seen       <= '0;
            r_seq_seen      <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                if (i_item.last_byte) begin
                    // packet done: start the next one from scratch
                    r_byte_count    <= '0;
                    r_header_offset <= '0;
                    r_type_seen     <= '0;
                    r_id_seen       <= '0;
                    r_seq_seen      <= '0;
                end else begin
                    r_byte_count    <= n_byte_count;
                    r_header_offset <= n_header_offset;
                    r_type_seen     <= n_type_seen;
                    r_id_seen       <= n_id_seen;
                    r_seq_seen      <= n_seq_seen;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.last_byte) begin
            r_verdict <= n_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign o_accepted  = (r_verdict == iem_pkg::VERDICT_MATCH);

endmodule

>>> hw/rtl/icmp_echo_reply_matcher.sv
// Top level of the ICMP echo reply matcher: configuration registers, input
// stage and parser. Depends on iem_pkg, iem_in_stage and iem_parser.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_stall    i_rx_byte, i_last_byte
//   out      from block o_out_valid / i_out_stall  o_accepted, o_verdict
//   cfg      to block   i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// One byte is taken per cycle while o_in_stall is low. After its last byte is
// accepted, a verdict passes the input register, then the verdict register,
// before o_out_valid rises.
// Synchronous active-low reset clears position, captures, config and valids.
// A stalled verdict holds; bytes keep flowing until a second last byte
// would need the occupied verdict register.
module icmp_echo_reply_matcher (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [iem_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic                            i_last_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_accepted,
    output logic [2:0]                      o_verdict,
    input  logic                            i_cfg_we,
    input  logic [iem_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [iem_pkg::CFG_DAT_W-1:0]   i_cfg_wdata
);

    iem_pkg::t_cfg     r_cfg;
    iem_pkg::t_in_item item;
    logic              take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                iem_pkg::REG_IPV6_MODE:    r_cfg.ipv6_mode    <= i_cfg_wdata[0];
                iem_pkg::REG_RAW_SOCKET:   r_cfg.raw_socket   <= i_cfg_wdata[0];
                iem_pkg::REG_EXPECTED_ID:  r_cfg.expected_id  <= i_cfg_wdata;
                iem_pkg::REG_EXPECTED_SEQ: r_cfg.expected_seq <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    iem_in_stage u_in_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .i_last_byte (i_last_byte),
        .i_take      (take),
        .o_item      (item)
    );

    iem_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item      (item),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_accepted  (o_accepted),
        .o_verdict   (o_verdict)
    );

`ifndef ASSERT_OFF
    a_accept_matches_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accepted == (o_verdict == iem_pkg::VERDICT_MATCH)))
        else $error("accepted flag disagrees with verdict");

    a_verdict_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict <= iem_pkg::VERDICT_ID))
        else $error("verdict code out of range");

    a_no_verdict_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("verdict valid right after reset");

    a_take_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> item.valid)
        else $error("parser took an empty input register");
`endif

endmodule
